>>> rtl/core/pmp_pkg.sv
// Shared widths, constants and types of the polyhedron mass properties unit.
// No dependencies; used by pmp_divider and polyhedron_mass_properties_unit.
`timescale 1ns / 1ps
package pmp_pkg;
  localparam int MaxVertices = 256;
  localparam int CoordBits   = 10;
  localparam int MaxFaces    = 1024;
  localparam int InCoordW    = 10;
  localparam int IndexW      = 8;
  localparam int VolW        = 41;
  localparam int CenW        = 52;
  localparam int MomW        = 63;
  localparam int CentOutW    = 18;
  localparam int NumW        = CenW + 6;  // magnitude of centroid sum times 64
  localparam int QuotW       = NumW;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_FACE   = 1'b1
  } op_e;

  // Request from the top level to the divider.
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [VolW-1:0] den;
  } div_req_t;

  // Status from the divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;
endpackage

>>> rtl/core/pmp_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pmp_pkg for widths and the request and status structs.
`timescale 1ns / 1ps
module pmp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmp_pkg::div_req_t req_i,
  output pmp_pkg::div_rsp_t rsp_o
);
  localparam int CntW = $clog2(pmp_pkg::NumW + 1);

  logic [pmp_pkg::VolW:0]    rem_q, rem_d;
  logic [pmp_pkg::NumW-1:0]  num_q, num_d;
  logic [pmp_pkg::VolW-1:0]  den_q, den_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [pmp_pkg::VolW+1:0]  trial;
  logic [pmp_pkg::VolW+1:0]  shifted;

  always_comb begin
    rem_d = rem_q; num_d = num_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q, num_q[pmp_pkg::NumW-1]};
    trial = shifted - {2'b00, den_q};
    if (req_i.start) begin
      rem_d = '0; num_d = req_i.num; den_d = req_i.den;
      cnt_d = CntW'(pmp_pkg::NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[pmp_pkg::NumW-2:0], ~trial[pmp_pkg::VolW+1]};
      rem_d = trial[pmp_pkg::VolW+1] ? shifted[pmp_pkg::VolW:0] : trial[pmp_pkg::VolW:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; num_q <= num_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
endmodule

>>> rtl/core/polyhedron_mass_properties_unit.sv
// Polyhedron mass properties unit: volume, centroid and second moments.
// A vertex word never stalls the input. A face word stalls the input after it is taken
// (three store reads, products, six moment multiply-adds) until the unit is idle again.
// A last face then adds three divider runs (one per axis) and an output step; the result
// skips the divider when the volume is zero, and waits in S_OUT only while the output is held.
// Reset clears the sums and control; the vertex store is undefined until written.
`timescale 1ns / 1ps
module polyhedron_mass_properties_unit #(
  parameter int MAX_VERTICES = pmp_pkg::MaxVertices,
  parameter int COORD_BITS   = pmp_pkg::CoordBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic                                operation_i,
  input  logic [pmp_pkg::IndexW-1:0]          vertex_index_i,
  input  logic signed [pmp_pkg::InCoordW-1:0] vertex_x_i,
  input  logic signed [pmp_pkg::InCoordW-1:0] vertex_y_i,
  input  logic signed [pmp_pkg::InCoordW-1:0] vertex_z_i,
  input  logic [pmp_pkg::IndexW-1:0]          face_first_i,
  input  logic [pmp_pkg::IndexW-1:0]          face_second_i,
  input  logic [pmp_pkg::IndexW-1:0]          face_third_i,
  input  logic                                last_face_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [pmp_pkg::VolW-1:0]     volume_times_six_o,
  output logic signed [pmp_pkg::CentOutW-1:0] centroid_x_o,
  output logic signed [pmp_pkg::CentOutW-1:0] centroid_y_o,
  output logic signed [pmp_pkg::CentOutW-1:0] centroid_z_o,
  output logic signed [pmp_pkg::MomW-1:0]     second_moment_xx_o,
  output logic signed [pmp_pkg::MomW-1:0]     second_moment_yy_o,
  output logic signed [pmp_pkg::MomW-1:0]     second_moment_zz_o,
  output logic signed [pmp_pkg::MomW-1:0]     second_moment_xy_o,
  output logic signed [pmp_pkg::MomW-1:0]     second_moment_xz_o,
  output logic signed [pmp_pkg::MomW-1:0]     second_moment_yz_o,
  output logic                                degenerate_o
);
  // No face counter is kept; pmp_pkg::MaxFaces only bounds how large the sums
  // can grow, which the fixed sum widths already cover.
  localparam int AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW    = COORD_BITS;
  localparam int VolW = pmp_pkg::VolW;
  localparam int CenW = pmp_pkg::CenW;
  localparam int MomW = pmp_pkg::MomW;
  localparam int NumW = pmp_pkg::NumW;
  localparam int OutW = pmp_pkg::CentOutW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_CAP3, S_MINOR, S_DET, S_SUMS,
    S_MOM1, S_MOM2, S_ACC, S_DIV, S_DIVW, S_OUT
  } state_e;

  // Vertex store, one synchronous read or write port.
  logic [3*CW-1:0] store_mem [MAX_VERTICES];
  logic [3*CW-1:0] rd_data_q;
  logic [AddrW-1:0] addr;
  logic             we, rd_en;

  state_e state_q;
  logic [pmp_pkg::IndexW-1:0] idx_q [3];
  logic                       last_q;
  logic [1:0]                 oob_q;
  logic                       oob3;
  logic signed [CW-1:0]       a_q [3][3];   // [axis][corner]
  logic signed [2*CW+1:0]     minor_q [3];
  logic signed [VolW-1:0]     det_q;
  logic signed [CW+1:0]       rs_q [3];
  logic signed [2*CW+3:0]     e_q [6];
  logic [2:0]                 k_q;
  logic signed [MomW-1:0]     term_q;
  logic signed [VolW-1:0]     vol_q;
  logic signed [CenW-1:0]     cen_q [3];
  logic signed [MomW-1:0]     mom_q [6];
  logic [1:0]                 axis_q;
  logic signed [OutW-1:0]     cent_q [3];
  logic                       in_acc;
  logic [2:0]                 oob_n;

  pmp_pkg::div_req_t div_req;
  pmp_pkg::div_rsp_t div_rsp;

  pmp_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // Input is taken only in idle; a pending result does not block new words.
  assign stall_o = (state_q != S_IDLE);
  assign in_acc  = valid_i && !stall_o;

  function automatic logic signed [CW-1:0] trunc_coord(input logic [pmp_pkg::InCoordW-1:0] v);
    return $signed(v[CW-1:0]);
  endfunction

  function automatic logic slot_oob(input logic [pmp_pkg::IndexW-1:0] s);
    return ({{(32-pmp_pkg::IndexW){1'b0}}, s} >= MAX_VERTICES);
  endfunction

  always_comb begin
    we = 1'b0; rd_en = 1'b0; addr = AddrW'(vertex_index_i);
    case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i == pmp_pkg::OP_VERTEX && !slot_oob(vertex_index_i)) we = 1'b1;
        if (in_acc && operation_i == pmp_pkg::OP_FACE) begin
          rd_en = 1'b1; addr = AddrW'(face_first_i);
        end
      end
      S_RD1: begin rd_en = 1'b1; addr = AddrW'(idx_q[1]); end
      S_RD2: begin rd_en = 1'b1; addr = AddrW'(idx_q[2]); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) store_mem[addr] <= {trunc_coord(vertex_z_i), trunc_coord(vertex_y_i),
                                trunc_coord(vertex_x_i)};
    if (rd_en) rd_data_q <= store_mem[addr];
  end

  assign oob3 = slot_oob(idx_q[2]);
  assign oob_n = {oob3, oob_q};

  // Which pair of axes each moment uses: xx yy zz xy xz yz.
  function automatic logic [1:0] pair_r(input logic [2:0] k);
    case (k)
      3'd1: return 2'd1;
      3'd2: return 2'd2;
      3'd5: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction
  function automatic logic [1:0] pair_c(input logic [2:0] k);
    case (k)
      3'd0: return 2'd0;
      3'd1: return 2'd1;
      3'd3: return 2'd1;
      default: return 2'd2;
    endcase
  endfunction

  logic [NumW-1:0] cen_mag;
  logic [VolW-1:0] vol_mag;
  logic            cen_neg;
  logic [pmp_pkg::QuotW-1:0] lim;
  logic [pmp_pkg::QuotW-1:0] qsat;

  always_comb begin
    cen_neg = cen_q[axis_q][CenW-1] ^ vol_q[VolW-1];
    cen_mag = {(cen_q[axis_q][CenW-1] ? NumW'(-cen_q[axis_q]) : NumW'(cen_q[axis_q]))} << 6;
    vol_mag = vol_q[VolW-1] ? VolW'(-vol_q) : VolW'(vol_q);
    div_req.start = (state_q == S_DIV);
    div_req.num   = cen_mag;
    div_req.den   = vol_mag;
    lim  = cen_neg ? pmp_pkg::QuotW'(1) << (OutW-1) : (pmp_pkg::QuotW'(1) << (OutW-1)) - 1'b1;
    qsat = (div_rsp.quot > lim) ? lim : div_rsp.quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      vol_q <= '0;
      for (int i = 0; i < 3; i++) cen_q[i] <= '0;
      for (int i = 0; i < 6; i++) mom_q[i] <= '0;
    end else begin
      // The result register fills from S_OUT once free and empties when taken.
      if (state_q == S_OUT && (!valid_o || !stall_i)) begin
        valid_o <= 1'b1;
      end else if (valid_o && !stall_i) begin
        valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && operation_i == pmp_pkg::OP_FACE) begin
            idx_q[0] <= face_first_i; idx_q[1] <= face_second_i; idx_q[2] <= face_third_i;
            last_q <= last_face_i;
            oob_q[0] <= slot_oob(face_first_i);
            oob_q[1] <= slot_oob(face_second_i);
            state_q <= S_RD1;
          end
        end
        S_RD1, S_RD2, S_RD3: begin
          // Capture the corner that the previous cycle read.
          for (int ax = 0; ax < 3; ax++)
            a_q[ax][state_q == S_RD1 ? 0 : (state_q == S_RD2 ? 1 : 2)] <=
              oob_n[state_q == S_RD1 ? 0 : (state_q == S_RD2 ? 1 : 2)] ? '0 :
              $signed(rd_data_q[ax*CW +: CW]);
          state_q <= (state_q == S_RD1) ? S_RD2 : (state_q == S_RD2) ? S_CAP3 : S_MINOR;
        end
        S_CAP3: begin
          for (int ax = 0; ax < 3; ax++)
            a_q[ax][2] <= oob3 ? '0 : $signed(rd_data_q[ax*CW +: CW]);
          state_q <= S_MINOR;
        end
        S_MINOR: begin
          minor_q[0] <= (2*CW+2)'(a_q[1][1]*a_q[2][2]) - (2*CW+2)'(a_q[1][2]*a_q[2][1]);
          minor_q[1] <= (2*CW+2)'(a_q[1][0]*a_q[2][2]) - (2*CW+2)'(a_q[1][2]*a_q[2][0]);
          minor_q[2] <= (2*CW+2)'(a_q[1][0]*a_q[2][1]) - (2*CW+2)'(a_q[1][1]*a_q[2][0]);
          for (int ax = 0; ax < 3; ax++)
            rs_q[ax] <= (CW+2)'(a_q[ax][0]) + (CW+2)'(a_q[ax][1]) + (CW+2)'(a_q[ax][2]);
          state_q <= S_DET;
        end
        S_DET: begin
          det_q <= VolW'(a_q[0][0]*minor_q[0]) - VolW'(a_q[0][1]*minor_q[1])
                 + VolW'(a_q[0][2]*minor_q[2]);
          for (int k = 0; k < 6; k++)
            e_q[k] <= (2*CW+4)'(a_q[pair_r(3'(k))][0]*a_q[pair_c(3'(k))][0])
                    + (2*CW+4)'(a_q[pair_r(3'(k))][1]*a_q[pair_c(3'(k))][1])
                    + (2*CW+4)'(a_q[pair_r(3'(k))][2]*a_q[pair_c(3'(k))][2])
                    + (2*CW+4)'(rs_q[pair_r(3'(k))]*rs_q[pair_c(3'(k))]);
          state_q <= S_SUMS;
        end
        S_SUMS: begin
          vol_q <= vol_q + det_q;
          for (int ax = 0; ax < 3; ax++)
            cen_q[ax] <= cen_q[ax] + CenW'(det_q * rs_q[ax]);
          k_q <= '0;
          state_q <= S_MOM1;
        end
        S_MOM1: begin
          term_q <= MomW'(det_q * e_q[k_q]);
          state_q <= S_MOM2;
        end
        S_MOM2: begin
          mom_q[k_q] <= mom_q[k_q] + term_q;
          k_q <= k_q + 1'b1;
          state_q <= (k_q == 3'd5) ? S_ACC : S_MOM1;
        end
        S_ACC: begin
          axis_q <= '0;
          if (!last_q) state_q <= S_IDLE;
          else if (vol_q == '0) begin
            for (int ax = 0; ax < 3; ax++) cent_q[ax] <= '0;
            state_q <= S_OUT;
          end else state_q <= S_DIV;
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) begin
            cent_q[axis_q] <= cen_neg ? OutW'(-qsat) : OutW'(qsat);
            axis_q <= axis_q + 1'b1;
            state_q <= (axis_q == 2'd2) ? S_OUT : S_DIV;
          end
        end
        S_OUT: begin
          // Wait for the result register to be free, then load and clear.
          if (!valid_o || !stall_i) begin
            volume_times_six_o <= vol_q;
            centroid_x_o <= cent_q[0];
            centroid_y_o <= cent_q[1];
            centroid_z_o <= cent_q[2];
            second_moment_xx_o <= mom_q[0];
            second_moment_yy_o <= mom_q[1];
            second_moment_zz_o <= mom_q[2];
            second_moment_xy_o <= mom_q[3];
            second_moment_xz_o <= mom_q[4];
            second_moment_yz_o <= mom_q[5];
            degenerate_o <= (vol_q == '0);
            vol_q <= '0;
            for (int i = 0; i < 3; i++) cen_q[i] <= '0;
            for (int i = 0; i < 6; i++) mom_q[i] <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
